// ----- rtl/core/rgb_window_median_filter_defines.svh -----
// Assertion macros used by the filter control block.
`ifndef RGB_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define RGB_WINDOW_MEDIAN_FILTER_DEFINES_SVH

// The condition must never hold outside reset.
`define RWMF_ASSERT_NEVER(label, clk_s, rst_s, cond, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RWMF_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define RWMF_ASSERT_SAME(label, clk_s, rst_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/rwmf_pkg.sv -----
package rwmf_pkg;

  localparam int LANES = 3;
  localparam int CNT_W = 8;

  typedef logic [LANES-1:0][7:0] pixel_t;

  localparam logic [1:0] MODE_ZERO   = 2'd0;
  localparam logic [1:0] MODE_MIRROR = 2'd1;
  localparam logic [1:0] MODE_SHRINK = 2'd2;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;
  localparam logic [1:0] REG_MODE   = 2'd3;

  typedef struct packed {
    logic [10:0] width;
    logic [12:0] height;
    logic [1:0]  radius;
    logic [1:0]  mode;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic range;
    logic init;
    logic issue;
    logic decide;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic sweep_last;
    logic bit_zero;
    logic pos_last;
  } sts_t;

endpackage

// ----- rtl/core/rwmf_pix_if.sv -----
interface rwmf_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_c0;
  logic [7:0] pixel_c1;
  logic [7:0] pixel_c2;

  modport source(output valid, output pixel_c0, output pixel_c1, output pixel_c2,
                 input ready);
  modport sink(input valid, input pixel_c0, input pixel_c1, input pixel_c2,
               output ready);
endinterface

// ----- rtl/core/rwmf_res_if.sv -----
interface rwmf_res_if;
  logic        valid;
  logic        ready;
  logic [11:0] out_row;
  logic [9:0]  out_col;
  logic [7:0]  median_c0;
  logic [7:0]  median_c1;
  logic [7:0]  median_c2;
  logic        last_in_run;

  modport source(output valid, output out_row, output out_col, output median_c0,
                 output median_c1, output median_c2, output last_in_run, input ready);
  modport sink(input valid, input out_row, input out_col, input median_c0,
               input median_c1, input median_c2, input last_in_run, output ready);
endinterface

// ----- rtl/core/rwmf_ram.sv -----
module rwmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 7168
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/rwmf_ctrl.sv -----
`include "rgb_window_median_filter_defines.svh"

module rwmf_ctrl import rwmf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [2:0] {
    S_IDLE, S_RANGE, S_INIT, S_SWEEP, S_DRAIN, S_DECIDE, S_OUT
  } state_t;

  state_t state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      in_ready  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state    <= S_RANGE;
            in_ready <= 1'b0;
          end
        end
        S_RANGE: begin
          if (sts.empty) begin
            state    <= S_IDLE;
            in_ready <= 1'b1;
          end else begin
            state <= S_INIT;
          end
        end
        S_INIT: state <= S_SWEEP;
        S_SWEEP: begin
          if (sts.sweep_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_DECIDE;
        S_DECIDE: begin
          if (sts.bit_zero) begin
            state     <= S_OUT;
            out_valid <= 1'b1;
          end else begin
            state <= S_SWEEP;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (sts.pos_last) begin
              state    <= S_IDLE;
              in_ready <= 1'b1;
            end else begin
              state <= S_INIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd.accept  = (state == S_IDLE) && in_valid;
    cmd.range   = (state == S_RANGE);
    cmd.init    = (state == S_INIT);
    cmd.issue   = (state == S_SWEEP);
    cmd.decide  = (state == S_DECIDE);
    cmd.advance = (state == S_OUT) && out_ready && !sts.pos_last;
  end

  `RWMF_ASSERT_NEVER(a_no_overlap, clk, rst, in_ready && out_valid, "input and output both open")
  `RWMF_ASSERT_NEXT(a_accept_closes, clk, rst, in_valid && in_ready, !in_ready, "ready after transfer")
  `RWMF_ASSERT_NEXT(a_result_shown, clk, rst, (state == S_DECIDE) && sts.bit_zero, out_valid, "no result")

endmodule

// ----- rtl/core/rwmf_datapath.sv -----
module rwmf_datapath import rwmf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  pixel_t      pixel,
  output logic        ram_we,
  output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] ram_waddr,
  output pixel_t      ram_wdata,
  output logic [$clog2((2*MAX_RADIUS+1)*MAX_WIDTH)-1:0] ram_raddr,
  input  pixel_t      ram_rdata,
  output logic [11:0] out_row,
  output logic [9:0]  out_col,
  output pixel_t      median,
  output logic        last_in_run
);

  localparam int SIDE  = 2*MAX_RADIUS + 1;
  localparam int DEPTH = SIDE*MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = $clog2(SIDE);

  logic [13:0] w_eff;
  logic [12:0] h_eff;
  logic [2:0]  r_eff;
  logic [1:0]  mode;

  logic [10:0] col_q;
  logic [12:0] row_q;
  logic [SW-1:0] slot_q;
  logic [12:0] a_q;
  logic [10:0] b_q;
  logic [SW-1:0] aslot_q;

  logic [12:0] i_q, ihi_q;
  logic [10:0] j_q, jlo_q, jhi_q;
  logic signed [3:0] dy_q, dx_q;
  logic [2:0]  bit_q;
  logic [LANES-1:0][CNT_W-1:0] k_q, cnt_q;
  pixel_t      pfx_q;
  logic        rv_q, incl_q, zero_q;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    slot_inc = (s == SW'(SIDE-1)) ? '0 : s + 1'b1;
  endfunction

  assign w_eff = (cfg.width == '0) ? 14'd1 :
                 ({3'b0, cfg.width} > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : {3'b0, cfg.width};
  assign h_eff = (cfg.height == '0) ? 13'd1 :
                 (cfg.height > 13'd4096) ? 13'd4096 : cfg.height;
  assign r_eff = ({1'b0, cfg.radius} > 3'(MAX_RADIUS)) ? 3'(MAX_RADIUS) : {1'b0, cfg.radius};
  assign mode  = cfg.mode;

  // Position bookkeeping for the incoming pixel.
  logic [10:0] c0, c1;
  logic [12:0] r0, r1;
  logic [SW-1:0] s0, s1;

  always_comb begin
    c0 = col_q;
    r0 = row_q;
    s0 = slot_q;
    if ({3'b0, col_q} >= w_eff) begin
      c0 = '0;
      r0 = row_q + 1'b1;
      s0 = slot_inc(slot_q);
    end
    if (r0 >= h_eff) begin
      r0 = '0;
      s0 = '0;
    end
    c1 = c0 + 1'b1;
    r1 = r0;
    s1 = s0;
    if ({3'b0, c1} >= w_eff) begin
      c1 = '0;
      r1 = r0 + 1'b1;
      s1 = slot_inc(s0);
    end
    if (r1 >= h_eff) begin
      r1 = '0;
      s1 = '0;
    end
  end

  assign ram_we    = cmd.accept;
  assign ram_waddr = AW'(AW'(s0) * AW'(MAX_WIDTH) + AW'(c0));
  assign ram_wdata = pixel;

  // Output position range for the pixel just written.
  logic signed [14:0] as, bs, rs, hs, ws;
  logic row_last, col_last, row_ok, col_ok;
  logic signed [14:0] ilo_c, ihi_c, jlo_c, jhi_c;

  always_comb begin
    as = $signed({2'b0, a_q});
    bs = $signed({4'b0, b_q});
    rs = $signed({12'b0, r_eff});
    hs = $signed({2'b0, h_eff});
    ws = $signed({1'b0, w_eff});
    row_last = (as == hs - 15'sd1);
    col_last = (bs == ws - 15'sd1);
    row_ok = row_last || (as >= rs);
    col_ok = col_last || (bs >= rs);
    ilo_c = as - rs;
    ihi_c = as - rs;
    jlo_c = bs - rs;
    jhi_c = bs - rs;
    if (row_last) begin
      if (ilo_c < 0) ilo_c = '0;
      ihi_c = hs - 15'sd1;
    end
    if (col_last) begin
      if (jlo_c < 0) jlo_c = '0;
      jhi_c = ws - 15'sd1;
    end
  end

  // Window size for the current output position.
  logic signed [14:0] is, js, lo_y, hi_y, lo_x, hi_x;
  logic [3:0] rows_n, cols_n, side_n;
  logic [7:0] n_c;

  always_comb begin
    is = $signed({2'b0, i_q});
    js = $signed({4'b0, j_q});
    lo_y = is - rs;
    hi_y = is + rs;
    lo_x = js - rs;
    hi_x = js + rs;
    if (lo_y < 0) lo_y = '0;
    if (hi_y > hs - 15'sd1) hi_y = hs - 15'sd1;
    if (lo_x < 0) lo_x = '0;
    if (hi_x > ws - 15'sd1) hi_x = ws - 15'sd1;
    side_n = {r_eff, 1'b1};
    rows_n = (mode == MODE_SHRINK) ? 4'(hi_y - lo_y + 15'sd1) : side_n;
    cols_n = (mode == MODE_SHRINK) ? 4'(hi_x - lo_x + 15'sd1) : side_n;
    n_c = rows_n * cols_n;
  end

  // Address of one window entry.
  logic signed [14:0] y, x, my, mx, yu, xu;
  logic in_img, incl_c, zero_c;
  logic [3:0] diff, slot_c;

  always_comb begin
    y = is + 15'(dy_q);
    x = js + 15'(dx_q);
    in_img = (y >= 0) && (y < hs) && (x >= 0) && (x < ws);
    my = y;
    if (y > hs - 15'sd1) my = is - 15'(dy_q);
    else if (y < 0) my = -y;
    if (my < 0) my = '0;
    if (my > hs - 15'sd1) my = hs - 15'sd1;
    mx = x;
    if (x > ws - 15'sd1) mx = js - 15'(dx_q);
    else if (x < 0) mx = -x;
    if (mx < 0) mx = '0;
    if (mx > ws - 15'sd1) mx = ws - 15'sd1;
    yu = in_img ? y : is;
    xu = in_img ? x : js;
    incl_c = 1'b1;
    zero_c = 1'b0;
    case (mode)
      MODE_MIRROR: begin
        yu = my;
        xu = mx;
      end
      MODE_SHRINK: incl_c = in_img;
      default: zero_c = !in_img;
    endcase
    diff = 4'(as - yu);
    slot_c = ({{(4-SW){1'b0}}, aslot_q} >= diff) ? 4'(aslot_q) - diff
                                                 : 4'(aslot_q) + 4'(SIDE) - diff;
  end

  assign ram_raddr = AW'(AW'(slot_c) * AW'(MAX_WIDTH) + AW'(xu));

  logic [7:0] mask;
  assign mask = 8'hFE << bit_q;

  assign sts.empty      = !(row_ok && col_ok);
  assign sts.sweep_last = (dy_q == $signed({1'b0, r_eff})) && (dx_q == $signed({1'b0, r_eff}));
  assign sts.bit_zero   = (bit_q == 3'd0);
  assign sts.pos_last   = (i_q == ihi_q) && (j_q == jhi_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      col_q  <= '0;
      row_q  <= '0;
      slot_q <= '0;
      rv_q   <= 1'b0;
    end else begin
      rv_q <= cmd.issue;
      if (cmd.accept) begin
        col_q  <= c1;
        row_q  <= r1;
        slot_q <= s1;
      end
    end
  end

  always_ff @(posedge clk) begin
    incl_q <= incl_c;
    zero_q <= zero_c;
    if (cmd.accept) begin
      a_q     <= r0;
      b_q     <= c0;
      aslot_q <= s0;
    end
    if (cmd.range) begin
      i_q   <= 13'(ilo_c);
      ihi_q <= 13'(ihi_c);
      j_q   <= 11'(jlo_c);
      jlo_q <= 11'(jlo_c);
      jhi_q <= 11'(jhi_c);
    end
    if (cmd.advance) begin
      if (j_q == jhi_q) begin
        j_q <= jlo_q;
        i_q <= i_q + 1'b1;
      end else begin
        j_q <= j_q + 1'b1;
      end
    end
    if (cmd.init || cmd.decide) begin
      dy_q <= -$signed({1'b0, r_eff});
      dx_q <= -$signed({1'b0, r_eff});
    end else if (cmd.issue) begin
      if (dx_q == $signed({1'b0, r_eff})) begin
        dx_q <= -$signed({1'b0, r_eff});
        dy_q <= dy_q + 4'sd1;
      end else begin
        dx_q <= dx_q + 4'sd1;
      end
    end
    if (cmd.init) begin
      bit_q <= 3'd7;
    end else if (cmd.decide) begin
      bit_q <= bit_q - 1'b1;
    end
    for (int l = 0; l < LANES; l++) begin
      if (cmd.init) begin
        k_q[l]   <= n_c >> 1;
        pfx_q[l] <= '0;
        cnt_q[l] <= '0;
      end else if (cmd.decide) begin
        cnt_q[l] <= '0;
        if (k_q[l] >= cnt_q[l]) begin
          pfx_q[l][bit_q] <= 1'b1;
          k_q[l] <= k_q[l] - cnt_q[l];
        end
      end else if (rv_q && incl_q) begin
        if (zero_q) begin
          if ((pfx_q[l] & mask) == 8'd0) begin
            cnt_q[l] <= cnt_q[l] + 1'b1;
          end
        end else if ((((ram_rdata[l] ^ pfx_q[l]) & mask) == 8'd0) && !ram_rdata[l][bit_q]) begin
          cnt_q[l] <= cnt_q[l] + 1'b1;
        end
      end
    end
  end

  assign out_row     = i_q[11:0];
  assign out_col     = j_q[9:0];
  assign median      = pfx_q;
  assign last_in_run = sts.pos_last;

endmodule

// ----- rtl/core/rgb_window_median_filter.sv -----
// Per-channel median of a square window over a raster stream of RGB pixels.
// Input channel pix takes one pixel per transfer in raster order; output
// channel res gives the filtered pixel with its row and column, and
// last_in_run marks the final result caused by one input pixel.
// The APB port sets width, height, window radius and border mode; it is
// written only while the block is idle; the user must keep to this, as the block itself does not enforce it.
// Each input pixel is written into a line store of 2*MAX_RADIUS+1 rows. It
// then causes zero, one, or at row and frame ends up to (r+1)^2 results.
// Each result is found by a radix select over 8 bit planes, each plane
// sweeping the (2r+1)^2 window through the single line store read port.
// One pixel is handled at a time; pix.ready is high only while idle.
// A result is held on res until res.ready is high; the receiver can stall
// indefinitely and no result is lost.
// Synchronous reset clears the position counters to row 0, column 0 and
// sets the registers to width 1024, height 1024, radius 2, zero padding.
// The line store holds no reset value; it needs no clearing pass.
module rgb_window_median_filter import rwmf_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_RADIUS = 3
) (
  input  logic        clk,
  input  logic        rst,
  rwmf_pix_if.sink    pix,
  rwmf_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int DEPTH = (2*MAX_RADIUS+1)*MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  cfg_t   cfg;
  cmd_t   cmd;
  sts_t   sts;
  pixel_t pixel, median, ram_wdata, ram_rdata;
  logic   ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= 11'd1024;
      cfg.height <= 13'd1024;
      cfg.radius <= 2'd2;
      cfg.mode   <= MODE_ZERO;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_WIDTH:  cfg.width  <= pwdata[10:0];
        REG_HEIGHT: cfg.height <= pwdata[12:0];
        REG_RADIUS: cfg.radius <= pwdata[1:0];
        REG_MODE:   cfg.mode   <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = {21'd0, cfg.width};
      REG_HEIGHT: prdata = {19'd0, cfg.height};
      REG_RADIUS: prdata = {30'd0, cfg.radius};
      REG_MODE:   prdata = {30'd0, cfg.mode};
      default:    prdata = '0;
    endcase
  end

  assign pixel = {pix.pixel_c2, pix.pixel_c1, pix.pixel_c0};

  rwmf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pix.valid),
    .in_ready  (pix.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rwmf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (cmd),
    .sts         (sts),
    .pixel       (pixel),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_wdata   (ram_wdata),
    .ram_raddr   (ram_raddr),
    .ram_rdata   (ram_rdata),
    .out_row     (res.out_row),
    .out_col     (res.out_col),
    .median      (median),
    .last_in_run (res.last_in_run)
  );

  rwmf_ram #(
    .WIDTH ($bits(pixel_t)),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign res.median_c0 = median[0];
  assign res.median_c1 = median[1];
  assign res.median_c2 = median[2];

endmodule
